[sv/rssv_pkg.sv]
// types, constants and helper functions of the resonant sawtooth synth voice
package rssv_pkg;

   localparam int FRAC_W = 20;
   localparam int ENV_UPDATE_INTERVAL_DEF = 64;
   localparam int ONE_Q = 1 << FRAC_W;
   localparam int HALF_Q = ONE_Q / 2;
   localparam int AMP_FLOOR_Q = ONE_Q / 65536;
   localparam int MUL_A_W = 26;
   localparam int MUL_B_W = 32;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int FQ_W = PROD_W - FRAC_W;
   localparam int RECIP_SHIFT = 30;

   // log2(e), ln(2), 2/pi and pi/2 in Q.20
   localparam logic signed [MUL_B_W-1:0] LOG2E_Q = 32'sd1512775;
   localparam logic signed [MUL_B_W-1:0] LN2_Q = 32'sd726817;
   localparam logic signed [MUL_B_W-1:0] TWO_OVER_PI_Q = 32'sd667544;
   localparam logic signed [MUL_B_W-1:0] HALF_PI_Q = 32'sd1647099;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_NOTE_ON = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_SILENCE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      AMP_ATTACK = 2'd0,
      AMP_RELEASE = 2'd1,
      AMP_HOLD = 2'd2
   } amp_mode_type;

   typedef enum logic [2:0] {
      CSR_CUTOFF_BASE = 3'd0,
      CSR_ENV_DEPTH = 3'd1,
      CSR_RESONANCE_INV = 3'd2,
      CSR_ENV_DECAY = 3'd3,
      CSR_ATTACK_RATE = 3'd4,
      CSR_RELEASE_RATE = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_WB,
      ST_EMIT
   } state_type;

   typedef enum logic [4:0] {
      OP_W_RI,
      OP_X_LOG2E,
      OP_FRAC_LN2,
      OP_EXP_TP,
      OP_EXP_DIV,
      OP_W2_COS,
      OP_U_HALFPI,
      OP_R_SQ,
      OP_COS_PC,
      OP_COS_PCDIV,
      OP_COS_PS,
      OP_COS_PSDIV,
      OP_R_PS,
      OP_COS_K,
      OP_K_SQ,
      OP_ENV_DECAY,
      OP_OSC_AMP,
      OP_A_D1,
      OP_B_D2,
      OP_C_V,
      OP_AMP
   } op_type;

   function automatic logic signed [23:0] sat24(input logic signed [FQ_W-1:0] v);
      logic signed [23:0] r;
      if (v > 38'sd8388607) r = 24'sh7FFFFF;
      else if (v < -38'sd8388608) r = 24'sh800000;
      else r = v[23:0];
      return r;
   endfunction

   function automatic logic [21:0] clamp22(input logic signed [FQ_W-1:0] v);
      logic [21:0] r;
      if (v < 38'sd0) r = '0;
      else if (v > 38'sd4194303) r = '1;
      else r = v[21:0];
      return r;
   endfunction

   // pitch steps of the top octave, Q.20
   function automatic logic [19:0] top_octave(input logic [3:0] idx);
      logic [19:0] r;
      case (idx)
         4'd0: r = 20'd398127;
         4'd1: r = 20'd421801;
         4'd2: r = 20'd446882;
         4'd3: r = 20'd473455;
         4'd4: r = 20'd501609;
         4'd5: r = 20'd531436;
         4'd6: r = 20'd563037;
         4'd7: r = 20'd596516;
         4'd8: r = 20'd631987;
         4'd9: r = 20'd669567;
         4'd10: r = 20'd709381;
         4'd11: r = 20'd751563;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [21:0] note_pitch(input logic [6:0] note);
      logic [3:0] oct;
      logic [6:0] rem;
      logic [3:0] sh;
      logic [20:0] rnd;
      oct = '0;
      for (int k = 1; k <= 10; k++) begin
         if (note >= 7'(12 * k)) oct = 4'(k);
      end
      rem = note - (7'(oct) * 7'd12);
      sh = 4'd10 - oct;
      if (sh == 4'd0) begin
         rnd = {1'b0, top_octave(rem[3:0])};
      end else begin
         rnd = ({1'b0, top_octave(rem[3:0])} + (21'd1 << (sh - 4'd1))) >> sh;
      end
      return {2'b00, rnd[19:0]};
   endfunction

   // ceil(2^30 / d) for the exp series, d = 8 down to 1
   function automatic logic signed [MUL_B_W-1:0] exp_recip(input logic [2:0] step);
      logic signed [MUL_B_W-1:0] r;
      unique case (step)
         3'd0: r = 32'sd134217728;
         3'd1: r = 32'sd153391690;
         3'd2: r = 32'sd178956971;
         3'd3: r = 32'sd214748365;
         3'd4: r = 32'sd268435456;
         3'd5: r = 32'sd357913942;
         3'd6: r = 32'sd536870912;
         3'd7: r = 32'sd1073741824;
      endcase
      return r;
   endfunction

   // cosine series divisors 132, 90, 56, 30, 12, 2
   function automatic logic signed [MUL_B_W-1:0] cos_pc_recip(input logic [2:0] step);
      logic signed [MUL_B_W-1:0] r;
      case (step)
         3'd0: r = 32'sd8134408;
         3'd1: r = 32'sd11930465;
         3'd2: r = 32'sd19173962;
         3'd3: r = 32'sd35791395;
         3'd4: r = 32'sd89478486;
         3'd5: r = 32'sd536870912;
         default: r = '0;
      endcase
      return r;
   endfunction

   // sine series divisors 156, 110, 72, 42, 20, 6
   function automatic logic signed [MUL_B_W-1:0] cos_ps_recip(input logic [2:0] step);
      logic signed [MUL_B_W-1:0] r;
      case (step)
         3'd0: r = 32'sd6882961;
         3'd1: r = 32'sd9761290;
         3'd2: r = 32'sd14913081;
         3'd3: r = 32'sd25565282;
         3'd4: r = 32'sd53687092;
         3'd5: r = 32'sd178956971;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[sv/resonant_saw_synth_voice.sv]
// One synth voice: sawtooth oscillator, attack/release amplifier and a two-pole resonant
// low-pass filter whose coefficients follow a decaying envelope. Note on, release and
// silence transactions only update voice state. A sample tick gives one sample; a tick
// that refreshes the filter coefficients (the first after reset, after note on, after a
// release with refresh set, and every ENV_UPDATE_INTERVAL ticks) runs the refresh products
// first. Every product goes through one shared 26x32 multiplier: 5 products for a sample,
// 50 more for a coefficient refresh (exp and cos series, constant divisions done as
// reciprocal products). A new transaction is taken while a finished sample still waits
// on the output register.
module resonant_saw_synth_voice #(
   parameter int ENV_UPDATE_INTERVAL = rssv_pkg::ENV_UPDATE_INTERVAL_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_cmd,
   input  logic [6:0]          req_note,
   input  logic                req_refresh,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [23:0]  rsp_sample,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [21:0]         csr_wdata
);
   import rssv_pkg::*;

   localparam int CNT_W = $clog2(ENV_UPDATE_INTERVAL + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ENV_UPDATE_INTERVAL);

   // configuration
   logic [21:0] cutoff_base_ff, env_depth_ff, resonance_inv_ff;
   logic [20:0] env_decay_ff, attack_rate_ff, release_rate_ff;

   // voice state
   logic signed [23:0] osc_phase_ff;
   logic [21:0]        pitch_step_ff;
   logic [21:0]        amp_level_ff;
   amp_mode_type       amp_mode_ff;
   logic [21:0]        env_sweep_ff;
   logic signed [23:0] coef_a_ff, coef_b_ff, coef_c_ff;
   logic signed [23:0] delay_one_ff, delay_two_ff;
   logic [CNT_W-1:0]   update_count_ff;

   // sequencer
   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic      rsp_valid_ff;
   logic signed [23:0] rsp_sample_ff;

   // scratch
   logic [22:0]        wsum_ff;
   logic [24:0]        x_ff;
   logic [5:0]         expn_ff;
   logic [19:0]        frac_ff;
   logic [19:0]        t_ff;
   logic [21:0]        quo_ff;
   logic [20:0]        pser_ff;
   logic [20:0]        kval_ff;
   logic [1:0]         quad_ff;
   logic [20:0]        rval_ff;
   logic [21:0]        r2_ff;
   logic signed [21:0] pc_ff, ps_ff, cosv_ff;
   logic signed [22:0] vval_ff;
   logic signed [28:0] acc_ff;
   logic signed [23:0] y_ff;
   logic [2:0]         step_ff;
   logic signed [PROD_W-1:0] prod_ff;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  prod_adj;
   logic signed [FQ_W-1:0]    fq;
   logic [21:0]               dq;

   logic signed [22:0] one_minus_dq;
   logic [20:0]        k_next;
   logic signed [21:0] sval;
   logic signed [21:0] cos_sel;
   logic signed [23:0] coef_b_new, coef_c_new;
   logic signed [23:0] sample_new;
   logic signed [24:0] osc_sum;
   logic signed [23:0] osc_next;
   logic signed [23:0] half_minus_amp;
   logic [21:0]        amp_att, amp_rel;
   logic               accept;
   logic               emit_go;

   assign accept = req_valid && req_ready;
   assign emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   assign prod = mul_a * mul_b;
   // product scaled back to Q.20, truncated toward zero
   assign prod_adj = prod_ff + (prod_ff[PROD_W-1] ? PROD_W'(ONE_Q - 1) : PROD_W'(0));
   assign fq = prod_adj[PROD_W-1:FRAC_W];
   // quotient of a reciprocal product
   assign dq = prod_ff[RECIP_SHIFT+21:RECIP_SHIFT];

   assign one_minus_dq = 23'(ONE_Q) - $signed({1'b0, dq});
   assign k_next = (expn_ff >= 6'd22) ? 21'd0 : (one_minus_dq[20:0] >> expn_ff);
   assign sval = fq[21:0];
   assign coef_b_new = sat24(-fq);
   assign coef_c_new = sat24(FQ_W'(ONE_Q) - FQ_W'(coef_a_ff) - FQ_W'(coef_b_new));
   assign sample_new = sat24(FQ_W'(acc_ff) + fq);
   assign osc_sum = 25'(osc_phase_ff) + $signed({3'b000, pitch_step_ff});
   assign osc_next = (osc_sum > 25'(HALF_Q)) ? 24'(osc_sum - 25'(ONE_Q)) : osc_sum[23:0];
   assign half_minus_amp = 24'(HALF_Q) - $signed({2'b00, amp_level_ff});
   assign amp_att = clamp22(FQ_W'($signed({1'b0, amp_level_ff})) + fq);
   assign amp_rel = clamp22(fq);

   always_comb begin
      unique case (quad_ff)
         2'd0: cos_sel = pc_ff;
         2'd1: cos_sel = -sval;
         2'd2: cos_sel = -pc_ff;
         2'd3: cos_sel = sval;
      endcase
   end

   // next state and next operation
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && cmd_type'(req_cmd) == CMD_TICK) begin
               state_in = ST_MUL;
               op_in = (update_count_ff >= CNT_MAX) ? OP_W_RI : OP_OSC_AMP;
            end
         end
         ST_MUL: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            state_in = ST_MUL;
            unique case (op_ff)
               OP_W_RI:      op_in = OP_X_LOG2E;
               OP_X_LOG2E:   op_in = OP_FRAC_LN2;
               OP_FRAC_LN2:  op_in = OP_EXP_TP;
               OP_EXP_TP:    op_in = OP_EXP_DIV;
               OP_EXP_DIV:   op_in = (step_ff == 3'd7) ? OP_W2_COS : OP_EXP_TP;
               OP_W2_COS:    op_in = OP_U_HALFPI;
               OP_U_HALFPI:  op_in = OP_R_SQ;
               OP_R_SQ:      op_in = OP_COS_PC;
               OP_COS_PC:    op_in = OP_COS_PCDIV;
               OP_COS_PCDIV: op_in = OP_COS_PS;
               OP_COS_PS:    op_in = OP_COS_PSDIV;
               OP_COS_PSDIV: op_in = (step_ff == 3'd5) ? OP_R_PS : OP_COS_PC;
               OP_R_PS:      op_in = OP_COS_K;
               OP_COS_K:     op_in = OP_K_SQ;
               OP_K_SQ:      op_in = OP_ENV_DECAY;
               OP_ENV_DECAY: op_in = OP_OSC_AMP;
               OP_OSC_AMP:   op_in = OP_A_D1;
               OP_A_D1:      op_in = OP_B_D2;
               OP_B_D2:      op_in = OP_C_V;
               OP_C_V:       op_in = OP_AMP;
               OP_AMP: begin
                  state_in = ST_EMIT;
               end
            endcase
         end
         ST_EMIT: begin
            if (emit_go) state_in = ST_IDLE;
         end
      endcase
   end

   // handshake and multiplier operands
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mul_a = '0;
      mul_b = '0;
      unique case (op_ff)
         OP_W_RI: begin
            mul_a = {3'b000, wsum_ff};
            mul_b = {10'd0, resonance_inv_ff};
         end
         OP_X_LOG2E: begin
            mul_a = {1'b0, x_ff};
            mul_b = LOG2E_Q;
         end
         OP_FRAC_LN2: begin
            mul_a = {6'd0, frac_ff};
            mul_b = LN2_Q;
         end
         OP_EXP_TP: begin
            mul_a = {6'd0, t_ff};
            mul_b = {11'd0, pser_ff};
         end
         OP_EXP_DIV: begin
            mul_a = {4'd0, quo_ff};
            mul_b = exp_recip(step_ff);
         end
         OP_W2_COS: begin
            mul_a = {2'b00, wsum_ff, 1'b0};
            mul_b = TWO_OVER_PI_Q;
         end
         OP_U_HALFPI: begin
            mul_a = {6'd0, frac_ff};
            mul_b = HALF_PI_Q;
         end
         OP_R_SQ: begin
            mul_a = {5'd0, rval_ff};
            mul_b = {11'd0, rval_ff};
         end
         OP_COS_PC: begin
            mul_a = {4'd0, r2_ff};
            mul_b = {{10{pc_ff[21]}}, pc_ff};
         end
         OP_COS_PCDIV: begin
            mul_a = {4'd0, quo_ff};
            mul_b = cos_pc_recip(step_ff);
         end
         OP_COS_PS: begin
            mul_a = {4'd0, r2_ff};
            mul_b = {{10{ps_ff[21]}}, ps_ff};
         end
         OP_COS_PSDIV: begin
            mul_a = {4'd0, quo_ff};
            mul_b = cos_ps_recip(step_ff);
         end
         OP_R_PS: begin
            mul_a = {5'd0, rval_ff};
            mul_b = {{10{ps_ff[21]}}, ps_ff};
         end
         OP_COS_K: begin
            mul_a = {{4{cosv_ff[21]}}, cosv_ff};
            mul_b = {11'd0, kval_ff};
         end
         OP_K_SQ: begin
            mul_a = {5'd0, kval_ff};
            mul_b = {11'd0, kval_ff};
         end
         OP_ENV_DECAY: begin
            mul_a = {4'd0, env_sweep_ff};
            mul_b = {11'd0, env_decay_ff};
         end
         OP_OSC_AMP: begin
            mul_a = {{2{osc_phase_ff[23]}}, osc_phase_ff};
            mul_b = {10'd0, amp_level_ff};
         end
         OP_A_D1: begin
            mul_a = {{2{coef_a_ff[23]}}, coef_a_ff};
            mul_b = {{8{delay_one_ff[23]}}, delay_one_ff};
         end
         OP_B_D2: begin
            mul_a = {{2{coef_b_ff[23]}}, coef_b_ff};
            mul_b = {{8{delay_two_ff[23]}}, delay_two_ff};
         end
         OP_C_V: begin
            mul_a = {{2{coef_c_ff[23]}}, coef_c_ff};
            mul_b = {{9{vval_ff[22]}}, vval_ff};
         end
         OP_AMP: begin
            if (amp_mode_ff == AMP_RELEASE) begin
               mul_a = {4'd0, amp_level_ff};
               mul_b = {11'd0, release_rate_ff};
            end else begin
               mul_a = {{2{half_minus_amp[23]}}, half_minus_amp};
               mul_b = {11'd0, attack_rate_ff};
            end
         end
      endcase
   end

   // control, configuration and voice state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= OP_W_RI;
         rsp_valid_ff <= 1'b0;
         cutoff_base_ff <= '0;
         env_depth_ff <= '0;
         resonance_inv_ff <= 22'd3481375;
         env_decay_ff <= '0;
         attack_rate_ff <= 21'd58656;
         release_rate_ff <= 21'd1047501;
         osc_phase_ff <= '0;
         pitch_step_ff <= '0;
         amp_level_ff <= '0;
         amp_mode_ff <= AMP_HOLD;
         env_sweep_ff <= '0;
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
         delay_one_ff <= '0;
         delay_two_ff <= '0;
         update_count_ff <= CNT_MAX;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;

         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_CUTOFF_BASE:   cutoff_base_ff <= csr_wdata;
               CSR_ENV_DEPTH:     env_depth_ff <= csr_wdata;
               CSR_RESONANCE_INV: resonance_inv_ff <= csr_wdata;
               CSR_ENV_DECAY:     env_decay_ff <= csr_wdata[20:0];
               CSR_ATTACK_RATE:   attack_rate_ff <= csr_wdata[20:0];
               CSR_RELEASE_RATE:  release_rate_ff <= csr_wdata[20:0];
               default: ;
            endcase
         end

         if (accept) begin
            unique case (cmd_type'(req_cmd))
               CMD_TICK: ;
               CMD_NOTE_ON: begin
                  pitch_step_ff <= note_pitch(req_note);
                  amp_mode_ff <= AMP_ATTACK;
                  env_sweep_ff <= env_depth_ff;
                  update_count_ff <= CNT_MAX;
               end
               CMD_RELEASE: begin
                  amp_mode_ff <= AMP_RELEASE;
                  if (req_refresh) update_count_ff <= CNT_MAX;
               end
               CMD_SILENCE: begin
                  amp_mode_ff <= AMP_HOLD;
               end
            endcase
         end

         if (state_ff == ST_WB) begin
            case (op_ff)
               OP_COS_K: coef_a_ff <= sat24($signed({fq[FQ_W-2:0], 1'b0}));
               OP_K_SQ: begin
                  coef_b_ff <= coef_b_new;
                  coef_c_ff <= coef_c_new;
               end
               OP_ENV_DECAY: begin
                  env_sweep_ff <= clamp22(fq);
                  update_count_ff <= '0;
               end
               OP_C_V: begin
                  delay_two_ff <= delay_one_ff;
                  delay_one_ff <= sample_new;
                  update_count_ff <= update_count_ff + CNT_W'(1);
                  osc_phase_ff <= osc_next;
               end
               OP_AMP: begin
                  if (amp_mode_ff == AMP_ATTACK) begin
                     amp_level_ff <= amp_att;
                  end else if (amp_mode_ff == AMP_RELEASE) begin
                     // release floors to silence
                     if (amp_rel < 22'(AMP_FLOOR_Q)) begin
                        amp_level_ff <= '0;
                        amp_mode_ff <= AMP_HOLD;
                     end else begin
                        amp_level_ff <= amp_rel;
                     end
                  end
               end
               default: ;
            endcase
         end

         if (emit_go) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath scratch registers
   always_ff @(posedge clock) begin
      if (accept) wsum_ff <= {1'b0, cutoff_base_ff} + {1'b0, env_sweep_ff};
      if (state_ff == ST_MUL) prod_ff <= prod;
      if (emit_go) rsp_sample_ff <= y_ff;
      if (state_ff == ST_WB) begin
         case (op_ff)
            OP_W_RI: x_ff <= fq[24:0];
            OP_X_LOG2E: begin
               expn_ff <= fq[25:20];
               frac_ff <= fq[19:0];
            end
            OP_FRAC_LN2: begin
               t_ff <= fq[19:0];
               pser_ff <= 21'(ONE_Q);
               step_ff <= '0;
            end
            OP_EXP_TP: quo_ff <= fq[21:0];
            OP_EXP_DIV: begin
               pser_ff <= one_minus_dq[20:0];
               kval_ff <= k_next;
               step_ff <= step_ff + 3'd1;
            end
            OP_W2_COS: begin
               quad_ff <= fq[21:20];
               frac_ff <= fq[19:0];
            end
            OP_U_HALFPI: rval_ff <= fq[20:0];
            OP_R_SQ: begin
               r2_ff <= fq[21:0];
               pc_ff <= 22'(ONE_Q);
               ps_ff <= 22'(ONE_Q);
               step_ff <= '0;
            end
            OP_COS_PC: quo_ff <= fq[21:0];
            OP_COS_PCDIV: pc_ff <= one_minus_dq[21:0];
            OP_COS_PS: quo_ff <= fq[21:0];
            OP_COS_PSDIV: begin
               ps_ff <= one_minus_dq[21:0];
               step_ff <= step_ff + 3'd1;
            end
            OP_R_PS: cosv_ff <= cos_sel;
            OP_OSC_AMP: vval_ff <= fq[22:0];
            OP_A_D1: acc_ff <= fq[28:0];
            OP_B_D2: acc_ff <= acc_ff + fq[28:0];
            OP_C_V: y_ff <= sample_new;
            default: ;
         endcase
      end
   end

endmodule

[test/tb.sv]
// self-checking testbench for the resonant sawtooth synth voice
module tb;
   import rssv_pkg::*;

   localparam longint ONE = 64'sd1 << 20;
   localparam longint HALF = ONE / 2;
   localparam int UPDATE_INTERVAL = 64;

   class sample_scoreboard;
      longint cutoff_base, env_depth, res_inv, env_decay, attack_rate, release_rate;
      longint osc_phase, pitch_step, amp_level, env_sweep;
      longint coef_a, coef_b, coef_c, delay_one, delay_two;
      amp_mode_type amp_mode;
      int update_count;
      logic signed [23:0] sample_q[$];
      int errors;

      function new();
         cutoff_base = 0;
         env_depth = 0;
         res_inv = 3481375;
         env_decay = 0;
         attack_rate = 58656;
         release_rate = 1047501;
         osc_phase = 0;
         pitch_step = 0;
         amp_level = 0;
         amp_mode = AMP_HOLD;
         env_sweep = 0;
         coef_a = 0;
         coef_b = 0;
         coef_c = 0;
         delay_one = 0;
         delay_two = 0;
         update_count = UPDATE_INTERVAL;
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, longint v);
         case (idx)
            CSR_CUTOFF_BASE: cutoff_base = v & 64'h3FFFFF;
            CSR_ENV_DEPTH: env_depth = v & 64'h3FFFFF;
            CSR_RESONANCE_INV: res_inv = v & 64'h3FFFFF;
            CSR_ENV_DECAY: env_decay = v & 64'h1FFFFF;
            CSR_ATTACK_RATE: attack_rate = v & 64'h1FFFFF;
            CSR_RELEASE_RATE: release_rate = v & 64'h1FFFFF;
            default: ;
         endcase
      endfunction

      // products truncate toward zero
      function longint fmul(longint a, longint b);
         return (a * b) / ONE;
      endfunction

      function longint round30(longint v);
         return (v + 512) >>> 10;
      endfunction

      function longint sat24(longint v);
         if (v > 8388607) return 8388607;
         if (v < -8388608) return -8388608;
         return v;
      endfunction

      function longint clamp22(longint v);
         if (v < 0) return 0;
         if (v > 4194303) return 4194303;
         return v;
      endfunction

      function longint exp_neg(longint x);
         longint y, n, t, p;
         y = fmul(x, round30(1549082005));
         n = y >>> 20;
         t = fmul(y & (ONE - 1), round30(744261118));
         p = ONE;
         if (n >= 22) return 0;
         for (longint i = 8; i >= 1; i--) p = ONE - fmul(t, p) / i;
         return p >>> n;
      endfunction

      function longint cos_fx(longint y);
         longint u, r, r2, pc, ps;
         int quad;
         u = fmul(y, round30(683565276));
         quad = int'((u >>> 20) & 3);
         r = fmul(u & (ONE - 1), round30(1686629713));
         r2 = fmul(r, r);
         pc = ONE;
         ps = ONE;
         for (longint i = 12; i >= 2; i -= 2) begin
            pc = ONE - fmul(r2, pc) / (i * (i - 1));
            ps = ONE - fmul(r2, ps) / (i * (i + 1));
         end
         ps = fmul(r, ps);
         case (quad)
            0: return pc;
            1: return -ps;
            2: return -pc;
            default: return ps;
         endcase
      endfunction

      function void refresh_coefs();
         longint w, k;
         w = cutoff_base + env_sweep;
         k = exp_neg(fmul(w, res_inv));
         env_sweep = clamp22(fmul(env_sweep, env_decay));
         coef_a = sat24(2 * fmul(cos_fx(2 * w), k));
         coef_b = sat24(-fmul(k, k));
         coef_c = sat24(ONE - coef_a - coef_b);
      endfunction

      function void note_input(cmd_type cmd, logic [6:0] note, logic refresh);
         longint v, acc, y, s;
         int n, sh;
         case (cmd)
            CMD_NOTE_ON: begin
               n = int'(note);
               sh = 10 - n / 12;
               s = top_octave_step(n % 12);
               if (sh > 0) s = (s + (64'sd1 << (sh - 1))) >>> sh;
               pitch_step = s;
               amp_mode = AMP_ATTACK;
               env_sweep = env_depth;
               update_count = UPDATE_INTERVAL;
            end
            CMD_RELEASE: begin
               amp_mode = AMP_RELEASE;
               if (refresh) update_count = UPDATE_INTERVAL;
            end
            CMD_SILENCE: amp_mode = AMP_HOLD;
            default: begin
               if (update_count >= UPDATE_INTERVAL) begin
                  refresh_coefs();
                  update_count = 0;
               end
               v = fmul(osc_phase, amp_level);
               acc = fmul(coef_a, delay_one) + fmul(coef_b, delay_two) + fmul(coef_c, v);
               y = sat24(acc);
               delay_two = delay_one;
               delay_one = y;
               update_count++;
               osc_phase += pitch_step;
               if (osc_phase > HALF) osc_phase -= ONE;
               if (amp_mode == AMP_ATTACK) begin
                  amp_level = clamp22(amp_level + fmul(HALF - amp_level, attack_rate));
               end else if (amp_mode == AMP_RELEASE) begin
                  amp_level = clamp22(fmul(amp_level, release_rate));
                  // release floor: below 2^-16 the voice goes silent
                  if (amp_level < ONE / 65536) begin
                     amp_level = 0;
                     amp_mode = AMP_HOLD;
                  end
               end
               sample_q.push_back(y[23:0]);
            end
         endcase
      endfunction

      function longint top_octave_step(int idx);
         case (idx)
            0: return 398127;
            1: return 421801;
            2: return 446882;
            3: return 473455;
            4: return 501609;
            5: return 531436;
            6: return 563037;
            7: return 596516;
            8: return 631987;
            9: return 669567;
            10: return 709381;
            default: return 751563;
         endcase
      endfunction

      function void check_sample(logic signed [23:0] got);
         logic signed [23:0] want;
         if (sample_q.size() == 0) begin
            $error("unexpected sample: actual %0d", got);
            errors++;
         end else begin
            want = sample_q.pop_front();
            if (got !== want) begin
               $error("sample: expected %0d, actual %0d", want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready;
   logic [1:0] req_cmd;
   logic [6:0] req_note;
   logic req_refresh;
   logic rsp_valid, rsp_ready;
   logic signed [23:0] rsp_sample;
   logic csr_we;
   logic [2:0] csr_index;
   logic [21:0] csr_wdata;

   sample_scoreboard sb = new();
   bit calm = 1'b0;
   int stall_left = 0;

   resonant_saw_synth_voice dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: check and stall in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_sample(rsp_sample);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send(cmd_type cmd, logic [6:0] note, logic refresh);
      int gap;
      gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_note <= note;
      req_refresh <= refresh;
      do @(posedge clock); while (!req_ready);
      sb.note_input(cmd, note, refresh);
   endtask

   task automatic ticks(int n);
      repeat (n) send(CMD_TICK, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
   endtask

   // let every sample come out, then give the block time to settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.sample_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // write enable is left high; the caller drops it after the last write
   task automatic write_reg(csr_index_type idx, logic [21:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, longint'(val));
   endtask

   task automatic write_all(logic [21:0] cb, logic [21:0] ed, logic [21:0] ri,
                            logic [21:0] dc, logic [21:0] ar, logic [21:0] rr);
      write_reg(CSR_CUTOFF_BASE, cb);
      write_reg(CSR_ENV_DEPTH, ed);
      write_reg(CSR_RESONANCE_INV, ri);
      write_reg(CSR_ENV_DECAY, dc);
      write_reg(CSR_ATTACK_RATE, ar);
      write_reg(CSR_RELEASE_RATE, rr);
      csr_we <= 1'b0;
   endtask

   // one note: mostly well-formed, some noise
   task automatic phrase(ref int count);
      int n;
      send(CMD_NOTE_ON, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      n = $urandom_range(5, 70);
      ticks(n);
      send(CMD_RELEASE, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      count += n + 2;
      n = $urandom_range(5, 90);
      ticks(n);
      count += n;
      if ($urandom_range(0, 3) == 0) begin
         send(CMD_SILENCE, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
         ticks(3);
         count += 4;
      end
      if ($urandom_range(0, 2) == 0) begin
         repeat (6) send(cmd_type'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                         1'($urandom_range(0, 1)));
         count += 6;
      end
   endtask

   initial begin
      int count;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= CMD_TICK;
      req_note <= '0;
      req_refresh <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_CUTOFF_BASE;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset values, note extremes, release with and without refresh
      ticks(2);
      send(CMD_NOTE_ON, 7'd0, 1'b1);
      ticks(3);
      send(CMD_NOTE_ON, 7'd127, 1'b0);
      ticks(3);
      send(CMD_RELEASE, 7'd127, 1'b1);
      ticks(2);
      send(CMD_RELEASE, 7'd0, 1'b0);
      ticks(2);
      send(CMD_SILENCE, 7'd85, 1'b1);
      ticks(2);
      send(CMD_NOTE_ON, 7'd57, 1'b1);
      ticks(3);
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: write_all(22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0);
            1: write_all(22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'd1048576, 22'd1048576,
                         22'd1048576);
            2: write_all(22'd20000, 22'd400000, 22'd3481375, 22'd1040000, 22'd58656,
                         22'd1047501);
            default: write_all(22'($urandom_range(0, 4194303)), 22'($urandom_range(0, 4194303)),
                               22'($urandom_range(0, 4194303)),
                               22'($urandom_range(0, 1048576)),
                               22'($urandom_range(0, 1048576)),
                               22'($urandom_range(900000, 1048576)));
         endcase
         if (ph == 6) calm = 1'b1;
         count = 0;
         while (count < 215) begin
            phrase(count);
            // in phase 3, hold off until the voice has caught up
            if (ph == 3 && count > 100 && count < 200) begin
               req_valid <= 1'b0;
               while (sb.sample_q.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (sb.errors == 0 && sb.sample_q.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("tb: errors");
      $finish;
   end
endmodule
